[hdl/msft_pkg.sv]
// Shared types and constants for the multi-slot timer unit.
// Used by the controller, datapath, top level and checker.
package msft_pkg;

  localparam int SLOTS    = 16;
  localparam int TAG_BITS = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = 16;

  // port field widths
  localparam int SLOT_FW  = 4;
  localparam int TAG_FW   = 8;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 24;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_FIRE   = 3'd0,
    KIND_ADDED  = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_IDLE   = 3'd4
  } kind_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic stop;
    logic at_end;
    logic out_free;
  } stat_t;

endpackage

[hdl/multi_slot_followup_timer_unit.sv]
// Top level of the multi-slot timer unit.
// Depends on msft_pkg, msft_ctrl, msft_dpath (which holds msft_ram).
//
// Usage:
//   in_*  : one beat per operation; in_tuser carries the op (tick, add, remove).
//           add claims the lowest free slot, remove clears the first slot whose nonzero
//           handler tag and context tag match, tick counts down all active slots.
//   out_* : result beats; out_tuser is the kind, out_tlast marks the final
//           beat of an operation. A tick gives one fire beat per expired slot
//           in slot order, or a single idle beat.
// Timing:
//   The slot table is walked one slot per cycle, unless a stall holds it, through
//   the count/reload RAM (registered read, address issued one slot ahead). A tick
//   walks every slot; add and remove stop at the matching slot, or walk every
//   slot when nothing matches. One operation is in flight at a time.
//   The output register lets the final beat wait while the next op is taken.
// Reset: all slots inactive, tags zero, no result pending.
// Stall: a held output stalls a tick's walk at an expired slot while an earlier
//   fire is pending, and the final beat waits until the output register is free.
module multi_slot_followup_timer_unit
  import msft_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,  // period[15:0], periodic[16], handler[24:17], context_req[32:25]
  input  logic [1:0]        in_tuser,  // op[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata, // slot[3:0], fired_handler[11:4], fired_context[19:12]
  output logic [2:0]        out_tuser, // kind[2:0]
  output logic              out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  msft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msft_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

[hdl/msft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/msft_ctrl.sv]
// Sequencer for the timer unit: accept, walk the slot table, flush the final beat.
// Depends on msft_pkg.
module msft_ctrl
  import msft_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat.stall) begin
          cmd.step = 1'b1;
          if (stat.stop || stat.at_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hdl/msft_dpath.sv]
// Datapath: slot table, count/reload RAM, pending result and output register.
// Depends on msft_pkg and msft_ram.
module msft_dpath
  import msft_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  op_t                 op_r, op_nxt;
  logic [CNT_W-1:0]    period_r, period_nxt;
  logic                per_r, per_nxt;
  logic [TAG_BITS-1:0] h_r, h_nxt;
  logic [TAG_BITS-1:0] c_r, c_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;

  logic [SLOTS-1:0]    active_r, active_nxt;
  logic [SLOTS-1:0]    periodic_r, periodic_nxt;
  logic [TAG_BITS-1:0] handler_r [SLOTS];
  logic [TAG_BITS-1:0] handler_nxt [SLOTS];
  logic [TAG_BITS-1:0] context_r [SLOTS];
  logic [TAG_BITS-1:0] context_nxt [SLOTS];

  logic                pend_valid_r, pend_valid_nxt;
  kind_t               pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [TAG_BITS-1:0] pend_h_r, pend_h_nxt;
  logic [TAG_BITS-1:0] pend_c_r, pend_c_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [SLOT_FW-1:0]  out_slot_r, out_slot_nxt;
  logic [TAG_FW-1:0]   out_h_r, out_h_nxt;
  logic [TAG_FW-1:0]   out_c_r, out_c_nxt;
  logic                out_last_r, out_last_nxt;

  logic                  ram_we;
  logic [2*CNT_W-1:0]    ram_wdata;
  logic [2*CNT_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]      cur_cnt;
  logic [CNT_W-1:0]      cur_reload;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  cur_active;
  logic                  hit;
  logic                  out_free;

  // read address runs one slot ahead so data is ready on the next cycle
  msft_ram #(
    .WIDTH(2 * CNT_W),
    .DEPTH(SLOTS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(ram_wdata),
    .raddr(idx_nxt),
    .rdata(ram_rdata)
  );

  assign cur_cnt    = ram_rdata[CNT_W-1:0];
  assign cur_reload = ram_rdata[2*CNT_W-1:CNT_W];
  assign cnt_dec    = cur_cnt - CNT_W'(1);
  assign cur_active = active_r[idx_r];
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    case (op_r)
      OP_TICK:   hit = cur_active && (cnt_dec == '0);
      OP_ADD:    hit = !cur_active;
      OP_REMOVE: hit = (h_r != '0) && (handler_r[idx_r] == h_r) && (context_r[idx_r] == c_r);
      default:   hit = 1'b0;
    endcase
  end

  always_comb begin
    stat.stall    = (op_r == OP_TICK) && hit && pend_valid_r && !out_free;
    stat.stop     = hit && (op_r != OP_TICK);
    stat.at_end   = (idx_r == SLOT_W'(SLOTS - 1));
    stat.out_free = out_free;
  end

  always_comb begin
    op_nxt         = op_r;
    period_nxt     = period_r;
    per_nxt        = per_r;
    h_nxt          = h_r;
    c_nxt          = c_r;
    idx_nxt        = idx_r;
    active_nxt     = active_r;
    periodic_nxt   = periodic_r;
    handler_nxt    = handler_r;
    context_nxt    = context_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_slot_nxt  = pend_slot_r;
    pend_h_nxt     = pend_h_r;
    pend_c_nxt     = pend_c_r;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_h_nxt      = out_h_r;
    out_c_nxt      = out_c_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_wdata      = ram_rdata;

    if (cmd.start) begin
      op_nxt         = op_t'(in_tuser);
      period_nxt     = in_tdata[15:0];
      per_nxt        = in_tdata[16];
      h_nxt          = TAG_BITS'(in_tdata[24:17]);
      c_nxt          = TAG_BITS'(in_tdata[32:25]);
      idx_nxt        = '0;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.step) begin
      idx_nxt = idx_r + SLOT_W'(1);
      case (op_r)
        OP_TICK: begin
          if (cur_active) begin
            ram_we    = 1'b1;
            ram_wdata = {cur_reload, (hit && periodic_r[idx_r]) ? cur_reload : cnt_dec};
            if (hit) begin
              if (!periodic_r[idx_r]) begin
                active_nxt[idx_r] = 1'b0;
              end
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = pend_kind_r;
                out_slot_nxt  = SLOT_FW'(pend_slot_r);
                out_h_nxt     = TAG_FW'(pend_h_r);
                out_c_nxt     = TAG_FW'(pend_c_r);
                out_last_nxt  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_kind_nxt  = KIND_FIRE;
              pend_slot_nxt  = idx_r;
              pend_h_nxt     = handler_r[idx_r];
              pend_c_nxt     = context_r[idx_r];
            end
          end
        end
        OP_ADD: begin
          if (hit) begin
            ram_we                = 1'b1;
            ram_wdata             = {period_r, period_r};
            active_nxt[idx_r]     = 1'b1;
            periodic_nxt[idx_r]   = per_r;
            handler_nxt[idx_r]    = h_r;
            context_nxt[idx_r]    = c_r;
            pend_valid_nxt        = 1'b1;
            pend_kind_nxt         = KIND_ADDED;
            pend_slot_nxt         = idx_r;
            pend_h_nxt            = '0;
            pend_c_nxt            = '0;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            active_nxt[idx_r] = 1'b0;
            pend_valid_nxt    = 1'b1;
            pend_kind_nxt     = KIND_REMOVE;
            pend_slot_nxt     = idx_r;
            pend_h_nxt        = '0;
            pend_c_nxt        = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_kind_nxt = pend_kind_r;
        out_slot_nxt = SLOT_FW'(pend_slot_r);
        out_h_nxt    = TAG_FW'(pend_h_r);
        out_c_nxt    = TAG_FW'(pend_c_r);
      end else begin
        out_kind_nxt = (op_r == OP_TICK) ? KIND_IDLE : KIND_ERROR;
        out_slot_nxt = '0;
        out_h_nxt    = '0;
        out_c_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      periodic_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        handler_r[i] <= '0;
        context_r[i] <= '0;
      end
    end else begin
      active_r     <= active_nxt;
      periodic_r   <= periodic_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      handler_r    <= handler_nxt;
      context_r    <= context_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    period_r    <= period_nxt;
    per_r       <= per_nxt;
    h_r         <= h_nxt;
    c_r         <= c_nxt;
    idx_r       <= idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_h_r    <= pend_h_nxt;
    pend_c_r    <= pend_c_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_h_r     <= out_h_nxt;
    out_c_r     <= out_c_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DW - SLOT_FW - 2 * TAG_FW){1'b0}}, out_c_r, out_h_r, out_slot_r};

endmodule

[hdl/msft_chk.sv]
// Port-level checker for the multi-slot timer unit, bound to the top level.
// Depends on msft_pkg.
module msft_chk
  import msft_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [2:0]        out_tuser,
  input logic              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_FIRE) |-> out_tlast)
    else $error("non-fire result without last");

  a_tags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_FIRE) |-> (out_tdata[19:4] == '0))
    else $error("tags set on non-fire result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before walk");

endmodule

bind multi_slot_followup_timer_unit msft_chk u_chk (.*);
